### design/fbrop_pkg.sv
// Package for the framebuffer raster op engine: screen geometry, command codes,
// sequencer states and the segment table that splits a command into areas.
// No dependencies.
`timescale 1ns / 1ps
package fbrop_pkg;
	localparam int SCREEN_WIDTH  = 480;
	localparam int SCREEN_HEIGHT = 272;
	localparam int FB_DEPTH      = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int FB_AW         = $clog2(FB_DEPTH);
	localparam int XW            = $clog2(SCREEN_WIDTH);
	localparam int YW            = $clog2(SCREEN_HEIGHT);
	localparam int CW            = 13;
	localparam logic [31:0] INV_MASK = 32'hFF00_0000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [2:0] seg_idx_t;
	localparam seg_idx_t SEG_END = 3'd5;

	typedef enum logic [3:0] {
		OP_PIXEL    = 4'd0,
		OP_INV_PIX  = 4'd1,
		OP_HBYTE    = 4'd2,
		OP_VBYTE    = 4'd3,
		OP_HLINE    = 4'd4,
		OP_VLINE    = 4'd5,
		OP_RECT     = 4'd6,
		OP_INV_AREA = 4'd7,
		OP_CLR_AREA = 4'd8,
		OP_READ     = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		MODE_OPAQUE = 2'd0,
		MODE_TRANSP = 2'd1,
		MODE_INVERT = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	localparam logic [1:0] CFG_DRAW_COLOR = 2'd0;
	localparam logic [1:0] CFG_BACK_COLOR = 2'd1;
	localparam logic [1:0] CFG_DRAW_MODE  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEG,
		ST_RD,
		ST_WR
	} state_t;

	typedef struct packed {
		logic   valid;
		coord_t x0;
		coord_t x1;
		coord_t y0;
		coord_t y1;
	} seg_t;

	function automatic seg_t seg_bounds(input logic [3:0] op, input seg_idx_t k,
		input coord_t sx, input coord_t sy, input coord_t ex, input coord_t ey,
		input logic fill);
		seg_t s;
		s = '{valid: 1'b0, x0: sx, x1: sx, y0: sy, y1: sy};
		case (op)
			OP_PIXEL, OP_INV_PIX, OP_READ: s.valid = (k == 3'd0);
			OP_HBYTE: begin
				s.valid = (k == 3'd0);
				s.x1    = sx + coord_t'(7);
			end
			OP_VBYTE: begin
				s.valid = (k == 3'd0);
				s.y1    = sy + coord_t'(7);
			end
			OP_HLINE: begin
				s.valid = (k == 3'd0);
				s.x1    = ex;
			end
			OP_VLINE: begin
				s.valid = (k == 3'd0);
				s.y1    = ey;
			end
			OP_INV_AREA, OP_CLR_AREA: begin
				s.valid = (k == 3'd0);
				s.x1    = ex;
				s.y1    = ey;
			end
			OP_RECT: begin
				case (k)
					3'd0: begin
						s.valid = 1'b1;
						s.x1    = ex;
					end
					3'd1: begin
						s.valid = 1'b1;
						s.x1    = ex;
						s.y0    = ey;
						s.y1    = ey;
					end
					3'd2: begin
						s.valid = 1'b1;
						s.y1    = ey;
					end
					3'd3: begin
						s.valid = 1'b1;
						s.x0    = ex;
						s.x1    = ex;
						s.y1    = ey;
					end
					3'd4: begin
						s.valid = fill;
						s.x0    = sx + coord_t'(1);
						s.x1    = ex - coord_t'(1);
						s.y1    = ey;
					end
					default: s.valid = 1'b0;
				endcase
			end
			default: s.valid = 1'b0;
		endcase
		return s;
	endfunction
endpackage

### design/fbrop_ram.sv
// Single-port framebuffer memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module fbrop_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic [AW-1:0]    addr,
	input  logic             we,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### design/fbrop_seq.sv
// Command sequencer: splits a command into clipped areas and walks them one
// pixel at a time through a read then write pass on the framebuffer port.
// Depends on fbrop_pkg.
`timescale 1ns / 1ps
module fbrop_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [3:0]                    op,
	input  logic signed [11:0]            start_x,
	input  logic signed [11:0]            start_y,
	input  logic signed [11:0]            end_x,
	input  logic signed [11:0]            end_y,
	input  logic [7:0]                    pattern,
	input  logic [31:0]                   pixel_color,
	input  logic                          fill_flag,
	input  logic [31:0]                   draw_color,
	input  logic [31:0]                   back_color,
	input  logic [1:0]                    draw_mode,
	output logic [fbrop_pkg::FB_AW-1:0]   mem_addr,
	output logic                          mem_we,
	output logic [31:0]                   mem_wdata,
	input  logic [31:0]                   mem_rdata,
	output logic [31:0]                   read_color,
	output logic [3:0]                    op_done,
	output logic                          done
);
	fbrop_pkg::state_t   state_q, state_d;
	fbrop_pkg::seg_idx_t seg_q;
	fbrop_pkg::coord_t   sx_q, sy_q, ex_q, ey_q;
	fbrop_pkg::coord_t   x_q, y_q, x0_q, x1_q, y1_q;
	logic [3:0]          op_q;
	logic [7:0]          pat_q;
	logic [31:0]         pc_q;
	logic                fill_q;
	logic [31:0]         rd_q;
	logic                done_q;
	fbrop_pkg::seg_t     seg;
	fbrop_pkg::coord_t   cx0, cx1, cy0, cy1;
	logic                seg_go;
	logic [2:0]          bit_idx;
	logic                bit_set;
	logic                act_wr, act_inv;
	logic [31:0]         color;
	logic                last_x, last_y;

	assign seg = fbrop_pkg::seg_bounds(op_q, seg_q, sx_q, sy_q, ex_q, ey_q, fill_q);
	assign cx0 = (seg.x0 < 0) ? '0 : seg.x0;
	assign cx1 = (seg.x1 > fbrop_pkg::coord_t'(fbrop_pkg::SCREEN_WIDTH - 1)) ?
		fbrop_pkg::coord_t'(fbrop_pkg::SCREEN_WIDTH - 1) : seg.x1;
	assign cy0 = (seg.y0 < 0) ? '0 : seg.y0;
	assign cy1 = (seg.y1 > fbrop_pkg::coord_t'(fbrop_pkg::SCREEN_HEIGHT - 1)) ?
		fbrop_pkg::coord_t'(fbrop_pkg::SCREEN_HEIGHT - 1) : seg.y1;
	assign seg_go = seg.valid && (cx0 <= cx1) && (cy0 <= cy1);

	assign last_x = (x_q == x1_q);
	assign last_y = (y_q == y1_q);

	always_comb begin
		bit_idx = (op_q == fbrop_pkg::OP_HBYTE) ? 3'd7 - 3'(x_q - sx_q) : 3'(y_q - sy_q);
		bit_set = pat_q[bit_idx];
		act_wr  = 1'b0;
		act_inv = 1'b0;
		color   = draw_color;
		case (op_q)
			fbrop_pkg::OP_PIXEL: begin
				act_wr = 1'b1;
				color  = pc_q;
			end
			fbrop_pkg::OP_INV_PIX, fbrop_pkg::OP_INV_AREA: act_inv = 1'b1;
			fbrop_pkg::OP_HBYTE, fbrop_pkg::OP_VBYTE: begin
				case (draw_mode)
					fbrop_pkg::MODE_OPAQUE: begin
						act_wr = 1'b1;
						color  = bit_set ? draw_color : back_color;
					end
					fbrop_pkg::MODE_TRANSP: act_wr = bit_set;
					fbrop_pkg::MODE_INVERT: act_inv = bit_set;
					default: act_wr = 1'b0;
				endcase
			end
			fbrop_pkg::OP_HLINE, fbrop_pkg::OP_VLINE, fbrop_pkg::OP_RECT: begin
				act_inv = (draw_mode == fbrop_pkg::MODE_INVERT);
				act_wr  = (draw_mode != fbrop_pkg::MODE_INVERT);
			end
			fbrop_pkg::OP_CLR_AREA: begin
				act_wr = 1'b1;
				color  = back_color;
			end
			default: act_wr = 1'b0;
		endcase
	end

	assign mem_addr = fbrop_pkg::FB_AW'(y_q[fbrop_pkg::YW-1:0])
		* fbrop_pkg::FB_AW'(fbrop_pkg::SCREEN_WIDTH)
		+ fbrop_pkg::FB_AW'(x_q[fbrop_pkg::XW-1:0]);
	assign mem_we    = (state_q == fbrop_pkg::ST_WR) && (act_wr || act_inv);
	assign mem_wdata = act_inv ? (fbrop_pkg::INV_MASK | ~mem_rdata) : color;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbrop_pkg::ST_IDLE: if (start) state_d = fbrop_pkg::ST_SEG;
			fbrop_pkg::ST_SEG: begin
				if (seg_q == fbrop_pkg::SEG_END) state_d = fbrop_pkg::ST_IDLE;
				else if (seg_go) state_d = fbrop_pkg::ST_RD;
			end
			fbrop_pkg::ST_RD: state_d = fbrop_pkg::ST_WR;
			fbrop_pkg::ST_WR: state_d = (last_x && last_y) ? fbrop_pkg::ST_SEG : fbrop_pkg::ST_RD;
			default: state_d = fbrop_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbrop_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == fbrop_pkg::ST_SEG) && (seg_q == fbrop_pkg::SEG_END);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fbrop_pkg::ST_IDLE: begin
				if (start) begin
					op_q   <= op;
					sx_q   <= fbrop_pkg::coord_t'(start_x);
					sy_q   <= fbrop_pkg::coord_t'(start_y);
					ex_q   <= fbrop_pkg::coord_t'(end_x);
					ey_q   <= fbrop_pkg::coord_t'(end_y);
					pat_q  <= pattern;
					pc_q   <= pixel_color;
					fill_q <= fill_flag;
					seg_q  <= '0;
					rd_q   <= '0;
				end
			end
			fbrop_pkg::ST_SEG: begin
				if (seg_q != fbrop_pkg::SEG_END) begin
					seg_q <= seg_q + 3'd1;
					x_q   <= cx0;
					x0_q  <= cx0;
					x1_q  <= cx1;
					y_q   <= cy0;
					y1_q  <= cy1;
				end
			end
			fbrop_pkg::ST_RD: ;
			fbrop_pkg::ST_WR: begin
				if (op_q == fbrop_pkg::OP_READ) rd_q <= mem_rdata;
				if (!last_x) begin
					x_q <= x_q + fbrop_pkg::coord_t'(1);
				end else begin
					x_q <= x0_q;
					y_q <= y_q + fbrop_pkg::coord_t'(1);
				end
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != fbrop_pkg::ST_IDLE);
	assign done       = done_q;
	assign read_color = rd_q;
	assign op_done    = op_q;
endmodule

### design/framebuffer_raster_op_engine.sv
// Top level of the framebuffer raster op engine: configuration registers,
// command sequencer and framebuffer memory. Depends on fbrop_pkg, fbrop_seq, fbrop_ram.
//
// channel   | handshake                | payload
// ----------+--------------------------+------------------------------------------
// command   | start, busy              | op, start_x, start_y, end_x, end_y, pattern,
//           |                          | pixel_color, fill_flag
// result    | done (one-cycle strobe)  | read_color, op_done
// config    | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// A command holds busy through its five segment slots and the end check, plus a read
// and a write on the single read-then-write memory port for each on-screen pixel it touches.
// busy stays high from accept until done; done rises with busy falling.
// Reset clears control state, draw color and draw mode, and sets back color to all ones;
// framebuffer contents are undefined until written.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
module framebuffer_raster_op_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         op,
	input  logic signed [11:0] start_x,
	input  logic signed [11:0] start_y,
	input  logic signed [11:0] end_x,
	input  logic signed [11:0] end_y,
	input  logic [7:0]         pattern,
	input  logic [31:0]        pixel_color,
	input  logic               fill_flag,
	output logic               done,
	output logic [31:0]        read_color,
	output logic [3:0]         op_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	logic [31:0]                 draw_color_q;
	logic [31:0]                 back_color_q;
	logic [1:0]                  draw_mode_q;
	logic [fbrop_pkg::FB_AW-1:0] mem_addr;
	logic                        mem_we;
	logic [31:0]                 mem_wdata;
	logic [31:0]                 mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= '0;
			back_color_q <= '1;
			draw_mode_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fbrop_pkg::CFG_DRAW_COLOR: draw_color_q <= cfg_data;
				fbrop_pkg::CFG_BACK_COLOR: back_color_q <= cfg_data;
				fbrop_pkg::CFG_DRAW_MODE:  draw_mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	fbrop_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pattern     (pattern),
		.pixel_color (pixel_color),
		.fill_flag   (fill_flag),
		.draw_color  (draw_color_q),
		.back_color  (back_color_q),
		.draw_mode   (draw_mode_q),
		.mem_addr    (mem_addr),
		.mem_we      (mem_we),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata),
		.read_color  (read_color),
		.op_done     (op_done),
		.done        (done)
	);

	fbrop_ram #(
		.DEPTH (fbrop_pkg::FB_DEPTH),
		.WIDTH (32),
		.AW    (fbrop_pkg::FB_AW)
	) u_ram (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);
endmodule

### design/fbrop_checker.sv
// Port-level checker for the framebuffer raster op engine, with its bind.
// Depends on fbrop_pkg and framebuffer_raster_op_engine.
`timescale 1ns / 1ps
module fbrop_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [3:0]  op_done,
	input logic [31:0] read_color
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request accepted without going busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while still busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without a request in flight");
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (op_done != fbrop_pkg::OP_READ) |-> read_color == 32'd0)
		else $error("read_color nonzero for a non-read request");
endmodule

bind framebuffer_raster_op_engine fbrop_checker u_fbrop_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.op_done    (op_done),
	.read_color (read_color)
);

### bench/framebuffer_raster_op_engine_checker.sv
// Checker for the framebuffer raster op engine: tracks configuration writes,
// predicts each command's reply from its own framebuffer copy and compares replies.
// Depends on fbrop_pkg.
`timescale 1ns / 1ps
module framebuffer_raster_op_engine_checker
	import fbrop_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [3:0]         op,
	input  logic signed [11:0] start_x,
	input  logic signed [11:0] start_y,
	input  logic signed [11:0] end_x,
	input  logic signed [11:0] end_y,
	input  logic [7:0]         pattern,
	input  logic [31:0]        pixel_color,
	input  logic               fill_flag,
	input  logic               done,
	input  logic [31:0]        read_color,
	input  logic [3:0]         op_done,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending
);
	typedef struct {
		logic [31:0] color;
		logic [3:0]  code;
	} pixel_reply_t;

	logic [31:0]  screen [FB_DEPTH];
	logic [31:0]  ink;
	logic [31:0]  paper;
	mode_t        mode;
	pixel_reply_t replies_due[$];
	pixel_reply_t oldest;

	initial errors = 0;
	initial pending = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic bit visible(input int x, input int y);
		return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
	endfunction

	task automatic paint(input int x, input int y, input bit flip, input logic [31:0] c);
		int idx;
		if (visible(x, y)) begin
			idx = y * SCREEN_WIDTH + x;
			screen[idx] = flip ? (INV_MASK | ~screen[idx]) : c;
		end
	endtask

	task automatic paint_area(input int x0, input int x1, input int y0, input int y1,
		input bit flip, input logic [31:0] c);
		if (x0 < 0) x0 = 0;
		if (x1 > SCREEN_WIDTH - 1) x1 = SCREEN_WIDTH - 1;
		if (y0 < 0) y0 = 0;
		if (y1 > SCREEN_HEIGHT - 1) y1 = SCREEN_HEIGHT - 1;
		if (x0 > x1 || y0 > y1) return;
		for (int y = y0; y <= y1; y++)
			for (int x = x0; x <= x1; x++)
				paint(x, y, flip, c);
	endtask

	task automatic expand_bit(input int x, input int y, input bit set);
		case (mode)
			MODE_OPAQUE: paint(x, y, 1'b0, set ? ink : paper);
			MODE_TRANSP: if (set) paint(x, y, 1'b0, ink);
			MODE_INVERT: if (set) paint(x, y, 1'b1, 32'h0);
			default: ;
		endcase
	endtask

	task automatic predict_command;
		int sx, sy, ex, ey, lo, hi;
		bit flip;
		pixel_reply_t r;
		sx = int'(start_x);
		sy = int'(start_y);
		ex = int'(end_x);
		ey = int'(end_y);
		flip = (mode == MODE_INVERT);
		r.color = 32'h0;
		r.code = op;
		case (op)
			OP_PIXEL: paint(sx, sy, 1'b0, pixel_color);
			OP_INV_PIX: paint(sx, sy, 1'b1, 32'h0);
			OP_HBYTE: for (int i = 0; i < 8; i++) expand_bit(sx + i, sy, pattern[7 - i]);
			OP_VBYTE: for (int i = 0; i < 8; i++) expand_bit(sx, sy + i, pattern[i]);
			OP_HLINE: paint_area(sx, ex, sy, sy, flip, ink);
			OP_VLINE: paint_area(sx, sx, sy, ey, flip, ink);
			OP_RECT: begin
				paint_area(sx, ex, sy, sy, flip, ink);
				paint_area(sx, ex, ey, ey, flip, ink);
				paint_area(sx, sx, sy, ey, flip, ink);
				paint_area(ex, ex, sy, ey, flip, ink);
				if (fill_flag) begin
					lo = sx + 1 < 0 ? 0 : sx + 1;
					hi = ex - 1 > SCREEN_WIDTH - 1 ? SCREEN_WIDTH - 1 : ex - 1;
					for (int x = lo; x <= hi; x++) paint_area(x, x, sy, ey, flip, ink);
				end
			end
			OP_INV_AREA: paint_area(sx, ex, sy, ey, 1'b1, 32'h0);
			OP_CLR_AREA: paint_area(sx, ex, sy, ey, 1'b0, paper);
			OP_READ: if (visible(sx, sy)) r.color = screen[sy * SCREEN_WIDTH + sx];
			default: ;
		endcase
		replies_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink = 32'h0;
			paper = 32'hFFFF_FFFF;
			mode = MODE_OPAQUE;
			replies_due.delete();
			for (int i = 0; i < FB_DEPTH; i++) screen[i] = 32'h0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					report("unexpected reply", {28'h0, op_done}, 32'h0);
				end else begin
					oldest = replies_due.pop_front();
					if (read_color !== oldest.color) report("read_color", read_color, oldest.color);
					if (op_done !== oldest.code)
						report("op_done", {28'h0, op_done}, {28'h0, oldest.code});
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DRAW_COLOR: ink = cfg_data;
					CFG_BACK_COLOR: paper = cfg_data;
					CFG_DRAW_MODE: mode = mode_t'(cfg_data[1:0]);
					default: ;
				endcase
			end
			if (start && !busy) predict_command();
		end
		pending = replies_due.size();
	end
endmodule

### bench/framebuffer_raster_op_engine_test.sv
// Testbench top for the framebuffer raster op engine: clock, reset, configuration
// phases and command stimulus, with the verdict. Depends on fbrop_pkg, the engine
// and framebuffer_raster_op_engine_checker.
`timescale 1ns / 1ps
module framebuffer_raster_op_engine_test;
	import fbrop_pkg::*;

	localparam logic [3:0] OP_UNUSED_LO = 4'd10;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam int         PHASE_ITEMS  = 238;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [3:0]         op;
	logic signed [11:0] start_x;
	logic signed [11:0] start_y;
	logic signed [11:0] end_x;
	logic signed [11:0] end_y;
	logic [7:0]         pattern;
	logic [31:0]        pixel_color;
	logic               fill_flag;
	logic               done;
	logic [31:0]        read_color;
	logic [3:0]         op_done;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	int                 errors;
	int                 pending;
	int                 gap_pct;

	framebuffer_raster_op_engine i_dut (.*);

	framebuffer_raster_op_engine_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic issue(input logic [3:0] code, input logic [11:0] sx, input logic [11:0] sy,
		input logic [11:0] ex, input logic [11:0] ey, input logic [7:0] pat,
		input logic [31:0] color, input logic fill);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		op <= code;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		pattern <= pat;
		pixel_color <= color;
		fill_flag <= fill;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	function automatic logic [11:0] pick_coord(input int lim);
		if ($urandom_range(99) < 8) return 12'($urandom);
		return 12'(int'($urandom_range(lim + 20)) - 10);
	endfunction

	function automatic logic [11:0] pick_end(input logic [11:0] s);
		if ($urandom_range(99) < 2) return s + 12'($urandom_range(120));
		return s + 12'(int'($urandom_range(18)) - 4);
	endfunction

	task automatic random_command;
		logic [3:0]  code;
		logic [11:0] sx, sy;
		if ($urandom_range(99) < 3) code = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
		else code = 4'($urandom_range(OP_READ, OP_PIXEL));
		sx = pick_coord(SCREEN_WIDTH);
		sy = pick_coord(SCREEN_HEIGHT);
		issue(code, sx, sy, pick_end(sx), pick_end(sy), 8'($urandom), $urandom,
			1'($urandom));
	endtask

	task automatic directed_commands;
		issue(OP_CLR_AREA, 12'h800, 12'h800, 12'h7FF, 12'h7FF, 8'h00, 32'h0, 1'b0);
		issue(OP_READ, 12'd5, 12'd5, 12'd0, 12'd0, 8'h00, 32'h0, 1'b0);
		issue(OP_PIXEL, 12'd0, 12'd0, 12'h800, 12'h800, 8'hFF, 32'h0, 1'b1);
		issue(OP_PIXEL, 12'd479, 12'd271, 12'h7FF, 12'h7FF, 8'h00, 32'hFFFF_FFFF, 1'b0);
		issue(OP_PIXEL, 12'h800, 12'h7FF, 12'd0, 12'd0, 8'h00, 32'h1234_5678, 1'b0);
		issue(OP_READ, 12'd479, 12'd271, 12'd0, 12'd0, 8'h00, 32'h0, 1'b0);
		issue(OP_READ, 12'h7FF, 12'h7FF, 12'd0, 12'd0, 8'h00, 32'h0, 1'b0);
		issue(OP_INV_PIX, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00, 32'h0, 1'b0);
		issue(OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00, 32'h0, 1'b0);
		issue(OP_HBYTE, 12'd476, 12'd3, 12'd0, 12'd0, 8'h80, 32'h0, 1'b0);
		issue(OP_VBYTE, 12'd7, 12'd268, 12'd0, 12'd0, 8'h01, 32'h0, 1'b0);
		issue(OP_HBYTE, 12'hFFE, 12'd9, 12'd0, 12'd0, 8'hFF, 32'h0, 1'b0);
		issue(OP_HLINE, 12'd20, 12'd10, 12'd10, 12'd0, 8'h00, 32'h0, 1'b0);
		issue(OP_HLINE, 12'd470, 12'd11, 12'd490, 12'd0, 8'h00, 32'h0, 1'b0);
		issue(OP_VLINE, 12'd30, 12'hFFC, 12'd0, 12'd5, 8'h00, 32'h0, 1'b0);
		issue(OP_RECT, 12'd40, 12'd40, 12'd50, 12'd48, 8'h00, 32'h0, 1'b1);
		issue(OP_RECT, 12'd60, 12'd40, 12'd66, 12'd45, 8'h00, 32'h0, 1'b0);
		issue(OP_INV_AREA, 12'd42, 12'd41, 12'd52, 12'd46, 8'h00, 32'h0, 1'b0);
		issue(OP_CLR_AREA, 12'h800, 12'h7FF, 12'd3, 12'h800, 8'h00, 32'h0, 1'b0);
		issue(OP_READ, 12'd45, 12'd43, 12'd0, 12'd0, 8'h00, 32'h0, 1'b0);
		issue(OP_UNUSED_LO, 12'd1, 12'd1, 12'd9, 12'd9, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		issue(OP_UNUSED_HI, 12'd2, 12'd2, 12'd9, 12'd9, 8'h00, 32'h0, 1'b0);
	endtask

	initial begin
		logic [31:0] ink, paper;
		mode_t       mode;
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_PIXEL;
		start_x <= '0;
		start_y <= '0;
		end_x <= '0;
		end_y <= '0;
		pattern <= '0;
		pixel_color <= '0;
		fill_flag <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_DRAW_COLOR;
		cfg_data <= '0;
		gap_pct = 9;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 6; phase++) begin
			gap_pct = phase < 2 ? 9 : (phase < 4 ? 63 : 0);
			case (phase)
				0: begin
					ink = 32'h0;
					paper = 32'hFFFF_FFFF;
					mode = MODE_OPAQUE;
				end
				1: begin
					ink = 32'hFFFF_FFFF;
					paper = 32'h0;
					mode = MODE_TRANSP;
				end
				2, 4: begin
					ink = $urandom;
					paper = $urandom;
					mode = MODE_INVERT;
				end
				3: begin
					ink = $urandom;
					paper = $urandom;
					mode = MODE_NONE;
				end
				default: begin
					ink = $urandom;
					paper = $urandom;
					mode = MODE_OPAQUE;
				end
			endcase
			cfg_write(CFG_DRAW_COLOR, ink);
			cfg_write(CFG_BACK_COLOR, paper);
			cfg_write(CFG_DRAW_MODE, {30'h0, mode});
			cfg_valid <= 1'b0;
			@(posedge clk);
			if (phase == 0) directed_commands();
			for (int n = 0; n < PHASE_ITEMS; n++) random_command();
			drain();
		end
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
